// ===== rtl/core/lbp_pkg.sv =====
`timescale 1ns / 1ps
// lbp_pkg: widths, reset values and shared types for the 3x3 lbp pixel stream
// used by every module under rtl/core, no dependencies

package lbp_pkg;

    localparam int PATCH_W      = 7;
    localparam int PIX_W        = 8;
    localparam int IDX_W        = 6;
    localparam int MIN_SIZE     = 3;
    localparam int RESET_SIZE   = 32;
    localparam int MAX_SIZE_DEF = 64;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] row_idx;
        logic [IDX_W-1:0] col_idx;
    } t_pos;

endpackage

// ===== rtl/core/lbp_pos_ctr.sv =====
`timescale 1ns / 1ps
// lbp_pos_ctr: patch size register and raster row/column counters
// depends on lbp_pkg

module lbp_pos_ctr #(
    parameter int MAX_SIZE = lbp_pkg::MAX_SIZE_DEF,
    parameter int AW       = $clog2(MAX_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lbp_pkg::PATCH_W-1:0] i_cfg_wdata,
    input  logic                        i_adv,
    output logic [AW-1:0]               o_col,
    output lbp_pkg::t_pos               o_pos
);

    localparam int SW = ($clog2(MAX_SIZE + 1) > lbp_pkg::PATCH_W) ?
                        $clog2(MAX_SIZE + 1) : lbp_pkg::PATCH_W;

    logic [lbp_pkg::PATCH_W-1:0] r_size;
    logic [AW-1:0]               r_row;
    logic [AW-1:0]               r_col;
    logic [AW-1:0]               n_row;
    logic [AW-1:0]               n_col;
    logic [SW-1:0]               size_ext;
    logic [SW-1:0]               size_eff;
    logic                        col_end;
    logic                        row_end;

    always_comb begin
        size_ext = SW'(r_size);
        if (size_ext < SW'(lbp_pkg::MIN_SIZE)) begin
            size_eff = SW'(lbp_pkg::MIN_SIZE);
        end else if (size_ext > SW'(MAX_SIZE)) begin
            size_eff = SW'(MAX_SIZE);
        end else begin
            size_eff = size_ext;
        end
    end

    assign col_end = (SW'(r_col) == size_eff - SW'(1));
    assign row_end = (SW'(r_row) == size_eff - SW'(1));

    always_comb begin
        n_row = r_row;
        n_col = r_col + AW'(1);
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= lbp_pkg::PATCH_W'(lbp_pkg::RESET_SIZE);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_adv) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_col         = r_col;
    assign o_pos.emit    = (r_row >= AW'(2)) && (r_col >= AW'(2));
    assign o_pos.last    = row_end && col_end;
    assign o_pos.row_idx = lbp_pkg::IDX_W'(r_row) - lbp_pkg::IDX_W'(1);
    assign o_pos.col_idx = lbp_pkg::IDX_W'(r_col) - lbp_pkg::IDX_W'(1);

endmodule

// ===== rtl/core/lbp_line_mem.sv =====
`timescale 1ns / 1ps
// lbp_line_mem: the two line stores as one memory, upper row in the high byte
// depends on lbp_pkg

module lbp_line_mem #(
    parameter int DEPTH = lbp_pkg::MAX_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [2*lbp_pkg::PIX_W-1:0]   i_wr_data,
    output logic [2*lbp_pkg::PIX_W-1:0]   o_rd_data
);

    logic [2*lbp_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*lbp_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/lbp_win_core.sv =====
`timescale 1ns / 1ps
// lbp_win_core: 3x3 window, neighbour compares and the result register
// depends on lbp_pkg

module lbp_win_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_take,
    input  logic [lbp_pkg::PIX_W-1:0] i_pix,
    input  logic [lbp_pkg::PIX_W-1:0] i_top,
    input  logic [lbp_pkg::PIX_W-1:0] i_mid,
    input  lbp_pkg::t_pos             i_pos,
    output logic                      o_valid,
    output logic [lbp_pkg::PIX_W-1:0] o_code,
    output logic [lbp_pkg::IDX_W-1:0] o_row,
    output logic [lbp_pkg::IDX_W-1:0] o_col,
    output logic                      o_last
);

    logic [lbp_pkg::PIX_W-1:0] r_win [6];
    logic [lbp_pkg::PIX_W-1:0] n_code;
    logic [lbp_pkg::PIX_W-1:0] ctr;
    logic                      r_valid;
    logic [lbp_pkg::PIX_W-1:0] r_code;
    logic [lbp_pkg::IDX_W-1:0] r_row;
    logic [lbp_pkg::IDX_W-1:0] r_col;
    logic                      r_last;

    assign ctr = r_win[4];

    always_comb begin
        n_code[7] = r_win[0] > ctr;
        n_code[6] = r_win[3] > ctr;
        n_code[5] = i_top    > ctr;
        n_code[4] = i_mid    > ctr;
        n_code[3] = i_pix    > ctr;
        n_code[2] = r_win[5] > ctr;
        n_code[1] = r_win[2] > ctr;
        n_code[0] = r_win[1] > ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_top;
            r_win[4] <= i_mid;
            r_win[5] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_pos.emit;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_pos.emit) begin
            r_code <= n_code;
            r_row  <= i_pos.row_idx;
            r_col  <= i_pos.col_idx;
            r_last <= i_pos.last;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/lbp_3x3_pixel_stream.sv =====
`timescale 1ns / 1ps
// lbp_3x3_pixel_stream: 8-neighbour local binary pattern over a square 8-bit patch that
// arrives in raster order, one pixel per transaction; depends on lbp_pkg, lbp_pos_ctr,
// lbp_line_mem and lbp_win_core. A pixel is taken in every cycle unless a stalled result
// and a staged pixel fill both registers: the line memory is read at the pixel's column as
// it is accepted; when the staged pixel advances, the window is compared and the line
// memory written back, so a result enters the output register as the pixel one row below
// and one column right of its centre leaves the staging register. Only interior pixels
// give a result, o_last marks the final one, and the counters then start the next patch.
// Write i_cfg_wdata (patch size, clamped to 3..MAX_SIZE) only while no transaction is in
// flight; a write restarts the patch.

module lbp_3x3_pixel_stream #(
    parameter int MAX_SIZE = lbp_pkg::MAX_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lbp_pkg::PATCH_W-1:0] i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lbp_pkg::PIX_W-1:0]   i_pixel,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lbp_pkg::PIX_W-1:0]   o_lbp_code,
    output logic [lbp_pkg::IDX_W-1:0]   o_row_index,
    output logic [lbp_pkg::IDX_W-1:0]   o_col_index,
    output logic                        o_last
);

    localparam int AW = $clog2(MAX_SIZE);

    logic                        in_acc;
    logic                        s1_adv;
    logic                        out_free;
    logic [AW-1:0]               col;
    lbp_pkg::t_pos               pos;
    logic [2*lbp_pkg::PIX_W-1:0] rd_data;

    logic                        r_s1_vld;
    logic [lbp_pkg::PIX_W-1:0]   r_s1_pix;
    logic [AW-1:0]               r_s1_addr;
    lbp_pkg::t_pos               r_s1_pos;

    assign out_free = !o_valid || !i_stall;
    assign s1_adv   = r_s1_vld && out_free;
    assign o_stall  = r_s1_vld && !out_free;
    assign in_acc   = i_valid && !o_stall;

    lbp_pos_ctr #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW)
    ) u_pos_ctr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (in_acc),
        .o_col       (col),
        .o_pos       (pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= i_pixel;
            r_s1_addr <= col;
            r_s1_pos  <= pos;
        end
    end

    lbp_line_mem #(
        .DEPTH (MAX_SIZE),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (col),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({rd_data[lbp_pkg::PIX_W-1:0], r_s1_pix}),
        .o_rd_data (rd_data)
    );

    lbp_win_core u_win_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_take  (!i_stall),
        .i_pix   (r_s1_pix),
        .i_top   (rd_data[2*lbp_pkg::PIX_W-1:lbp_pkg::PIX_W]),
        .i_mid   (rd_data[lbp_pkg::PIX_W-1:0]),
        .i_pos   (r_s1_pos),
        .o_valid (o_valid),
        .o_code  (o_lbp_code),
        .o_row   (o_row_index),
        .o_col   (o_col_index),
        .o_last  (o_last)
    );

endmodule

// ===== rtl/core/lbp_chk.sv =====
`timescale 1ns / 1ps
// lbp_chk: port-level checks on the lbp pixel stream output, bound to the top level
// depends on lbp_pkg and lbp_3x3_pixel_stream

module lbp_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [lbp_pkg::PIX_W-1:0]   o_lbp_code,
    input  logic [lbp_pkg::IDX_W-1:0]   o_row_index,
    input  logic [lbp_pkg::IDX_W-1:0]   o_col_index,
    input  logic                        o_last
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lbp_code) &&
        $stable(o_row_index) && $stable(o_col_index) && $stable(o_last))
        else $error("stalled result changed");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_index != '0) && (o_col_index != '0))
        else $error("border position emitted");

    a_last_on_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_row_index == o_col_index)
        else $error("last not at final corner");

endmodule

bind lbp_3x3_pixel_stream lbp_chk u_lbp_chk (.*);
